>>> design/nid_pkg.sv
// shared types, codes and arithmetic helpers of the newton difference interpolator
package nid_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 64;

  // opcodes of a command beat
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // status codes of a result beat
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FEW   = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_SAT   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // register index decode
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic [63:0] SatMax = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SatMin = 64'h8000_0000_0000_0000;

  // completion of a multi-cycle arithmetic unit
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] value;
  } unit_res_t;

  // {saturated, value}
  function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return {1'b1, (d[64] ? SatMin : SatMax)};
    return {1'b0, d[63:0]};
  endfunction

  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} + {b[63], b};
    if (d[64] != d[63]) return {1'b1, (d[64] ? SatMin : SatMax)};
    return {1'b0, d[63:0]};
  endfunction

  function automatic logic [63:0] factorial(input logic [4:0] i);
    logic [63:0] f;
    case (i)
      5'd2:  f = 64'd2;
      5'd3:  f = 64'd6;
      5'd4:  f = 64'd24;
      5'd5:  f = 64'd120;
      5'd6:  f = 64'd720;
      5'd7:  f = 64'd5040;
      5'd8:  f = 64'd40320;
      5'd9:  f = 64'd362880;
      5'd10: f = 64'd3628800;
      5'd11: f = 64'd39916800;
      5'd12: f = 64'd479001600;
      5'd13: f = 64'd6227020800;
      5'd14: f = 64'd87178291200;
      5'd15: f = 64'd1307674368000;
      5'd16: f = 64'd20922789888000;
      5'd17: f = 64'd355687428096000;
      5'd18: f = 64'd6402373705728000;
      5'd19: f = 64'd121645100408832000;
      default: f = 64'd1;
    endcase
    return f;
  endfunction

endpackage

>>> design/nid_mul.sv
// q48.16 multiplier: exact 64x64 product from four 32x32 partial products, floor shift, saturate
module nid_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output nid_pkg::unit_res_t  res_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic         run_q;
  logic [2:0]   cnt_q;
  logic [63:0]  pp_q;
  logic [6:0]   sh_q;
  logic [127:0] acc_q;
  logic         done_q, sat_q;
  logic [63:0]  val_q;

  logic [31:0]  pa, pb;
  logic [111:0] qr;
  logic [63:0]  limit;
  logic         ovf;

  always_comb begin
    case (cnt_q)
      3'd0:    begin pa = ua_q[31:0];  pb = ub_q[31:0];  end
      3'd1:    begin pa = ua_q[31:0];  pb = ub_q[63:32]; end
      3'd2:    begin pa = ua_q[63:32]; pb = ub_q[31:0];  end
      default: begin pa = ua_q[63:32]; pb = ub_q[63:32]; end
    endcase
    // floor for negative products means rounding the magnitude up
    qr    = acc_q[127:16] + {111'd0, (neg_q && (acc_q[15:0] != 16'd0))};
    limit = neg_q ? nid_pkg::SatMin : nid_pkg::SatMax;
    ovf   = (qr[111:64] != 48'd0) || (qr[63:0] > limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[63] ? (64'd0 - a_i) : a_i;
      ub_q  <= b_i[63] ? (64'd0 - b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q <= 3'd3) begin
        pp_q <= pa * pb;
        sh_q <= (cnt_q == 3'd0) ? 7'd0 : ((cnt_q == 3'd3) ? 7'd64 : 7'd32);
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) acc_q <= acc_q + ({64'd0, pp_q} << sh_q);
      if (cnt_q == 3'd5) begin
        sat_q <= ovf;
        if (ovf) val_q <= neg_q ? nid_pkg::SatMin : nid_pkg::SatMax;
        else     val_q <= neg_q ? (64'd0 - qr[63:0]) : qr[63:0];
      end
    end
  end

  assign res_o = '{done: done_q, sat: sat_q, value: val_q};

endmodule

>>> design/nid_div.sv
// signed 64-bit divider, truncating toward zero, one quotient bit per cycle
module nid_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  output nid_pkg::unit_res_t  res_o
);

  logic        run_q, done_q, neg_q;
  logic [6:0]  cnt_q;
  logic [64:0] rem_q;
  logic [63:0] quo_q, den_q, val_q;
  logic [64:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh = {rem_q[63:0], quo_q[63]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q <= den_i[63] ? (64'd0 - den_i) : den_i;
      neg_q <= num_i[63] ^ den_i[63];
      rem_q <= '0;
    end else if (run_q) begin
      if (cnt_q < 7'd64) begin
        rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quo_q <= {quo_q[62:0], fits};
      end else begin
        val_q <= neg_q ? (64'd0 - quo_q) : quo_q;
      end
    end
  end

  assign res_o = '{done: done_q, sat: 1'b0, value: val_q};

endmodule

>>> design/newton_difference_interpolator.sv
// top level of the newton difference interpolator: sample and difference memories, sequencer
// Command block: a beat is taken when start is high and busy is low. Append (opcode 0)
// writes the ordinate into the sample memory and answers in the next cycle with done_o,
// result 0 and status ok or store full; busy stays low, so appends run one per cycle.
// Clear (opcode 2) and opcode 3 give no result. A query (opcode 1) with fewer than two
// points or zero spacing answers in the next cycle with status 1 or 2. Otherwise busy
// rises and the query runs: a divide for p (start, 64 quotient bits, result), a copy of
// the samples into the difference memory, then for j = 1..n-1 one in-place difference
// pass through the difference memory (one read and one write per cycle) followed by one
// q48.16 multiply (two from j = 2 on) and a divide by j!, and a final state to saturate
// the sum. Most of the query time is spent in the serial divider. done_o is high for
// exactly one cycle per result and cannot be held off by the receiver.
module newton_difference_interpolator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic signed [31:0] query_point_i,
  output logic               done_o,
  output logic signed [31:0] result_value_o,
  output logic [2:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PDIV = 8'b0000_0010,
    S_COPY = 8'b0000_0100,
    S_PASS = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MUL2 = 8'b0010_0000,
    S_TDIV = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q;

  // configuration
  logic dir_q;

  // point bookkeeping
  logic [CW-1:0] count_q;
  logic [31:0]   first_q, second_q, last_q;

  // memories
  logic [31:0] samp_mem [MAX_POINTS];
  logic [63:0] diff_mem [MAX_POINTS];
  logic [31:0] samp_rd_q;
  logic [63:0] diff_rd_q;
  logic          swe, dwe;
  logic [IW-1:0] sra, dra, dwa;
  logic [63:0]   dwd;

  // query datapath
  logic [63:0]   pnum_q, h_q, p_q, prod_q, coef_q, term_q, sum_q, prev_q;
  logic          sat_q;
  logic [CW-1:0] c_q, j_q, k_q;
  logic          mul_start_q, div_start_q;

  // result beat
  logic        done_q;
  logic [31:0] result_q;
  logic [2:0]  status_q;

  nid_pkg::unit_res_t mul_res, div_res;
  logic [63:0] mul_b, div_num, div_den, factor, jm1;
  logic [64:0] pass_res, add_res;
  logic [CW-1:0] sel_idx, rd_addr_c, wr_addr_c;
  logic [32:0] hdiff, qdiff;
  logic        accept, cfg_wr;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == nid_pkg::REG_DIRECTION) ? {31'd0, dir_q} : 32'd0;

  // spacing and scaled offset for p, taken at the command beat
  assign hdiff = {second_q[31], second_q} - {first_q[31], first_q};
  assign qdiff = dir_q ? ({query_point_i[31], query_point_i} - {last_q[31], last_q})
                       : ({query_point_i[31], query_point_i} - {first_q[31], first_q});

  always_comb begin
    jm1     = {{(64-CW){1'b0}}, j_q - CW'(1)} << nid_pkg::FracBits;
    factor  = dir_q ? (p_q + jm1) : (p_q - jm1);
    mul_b   = (state_q == S_MUL1) ? factor : coef_q;
    div_num = (state_q == S_PDIV) ? pnum_q : term_q;
    div_den = (state_q == S_PDIV) ? h_q : nid_pkg::factorial(5'(j_q));
    sel_idx = dir_q ? (count_q - CW'(1)) : '0;
    // forward pass walks up from entry 0, backward pass walks down from the last entry
    rd_addr_c = dir_q ? (count_q - CW'(1) - k_q) : k_q;
    wr_addr_c = dir_q ? (count_q + CW'(1) - k_q) : (k_q - CW'(2));
    pass_res  = dir_q ? nid_pkg::sat_sub(prev_q, diff_rd_q)
                      : nid_pkg::sat_sub(diff_rd_q, prev_q);
    add_res   = nid_pkg::sat_add(sum_q, div_res.value);

    swe = accept && (opcode_i == nid_pkg::OP_APPEND) && (count_q < CW'(MAX_POINTS));
    sra = c_q[IW-1:0];
    dra = rd_addr_c[IW-1:0];
    dwe = 1'b0;
    dwa = '0;
    dwd = pass_res[63:0];
    if (state_q == S_COPY && c_q != '0) begin
      dwe = 1'b1;
      dwa = IW'(c_q - CW'(1));
      dwd = {{32{samp_rd_q[31]}}, samp_rd_q};
    end else if (state_q == S_PASS && k_q >= CW'(2)) begin
      dwe = 1'b1;
      dwa = wr_addr_c[IW-1:0];
    end
  end

  // sample and difference memories, registered reads
  always_ff @(posedge clk_i) begin
    if (swe) samp_mem[count_q[IW-1:0]] <= y_value_i;
    samp_rd_q <= samp_mem[sra];
    if (dwe) diff_mem[dwa] <= dwd;
    diff_rd_q <= diff_mem[dra];
  end

  nid_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (prod_q),
    .b_i     (mul_b),
    .res_o   (mul_res)
  );

  nid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  // control: state, counters, bookkeeping, result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dir_q       <= 1'b0;
      count_q     <= '0;
      first_q     <= '0;
      second_q    <= '0;
      last_q      <= '0;
      done_q      <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      c_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      done_q      <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (cfg_wr && paddr[2] == nid_pkg::REG_DIRECTION) dir_q <= pwdata[0];
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode_i)
              nid_pkg::OP_APPEND: begin
                done_q <= 1'b1;
                if (count_q < CW'(MAX_POINTS)) begin
                  if (count_q == CW'(0)) first_q  <= x_value_i;
                  if (count_q == CW'(1)) second_q <= x_value_i;
                  last_q  <= x_value_i;
                  count_q <= count_q + CW'(1);
                end
              end
              nid_pkg::OP_QUERY: begin
                if (count_q < CW'(2) || hdiff == 33'd0) begin
                  done_q <= 1'b1;
                end else begin
                  state_q     <= S_PDIV;
                  div_start_q <= 1'b1;
                end
              end
              nid_pkg::OP_CLEAR: count_q <= '0;
              default: ;
            endcase
          end
        end
        S_PDIV: begin
          if (div_res.done) begin
            state_q <= S_COPY;
            c_q     <= '0;
          end
        end
        S_COPY: begin
          if (c_q == count_q) begin
            state_q <= S_PASS;
            j_q     <= CW'(1);
            k_q     <= '0;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        S_PASS: begin
          if (k_q == count_q - j_q + CW'(1)) begin
            if (j_q == CW'(1)) begin
              state_q <= S_MUL2;
            end else begin
              state_q <= S_MUL1;
            end
            mul_start_q <= 1'b1;
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        S_MUL1: begin
          if (mul_res.done) begin
            state_q     <= S_MUL2;
            mul_start_q <= 1'b1;
          end
        end
        S_MUL2: begin
          if (mul_res.done) begin
            state_q     <= S_TDIV;
            div_start_q <= 1'b1;
          end
        end
        S_TDIV: begin
          if (div_res.done) begin
            if (j_q == count_q - CW'(1)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_PASS;
              j_q     <= j_q + CW'(1);
              k_q     <= '0;
            end
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sat_q    <= 1'b0;
          h_q      <= {{31{hdiff[32]}}, hdiff};
          pnum_q   <= {{15{qdiff[32]}}, qdiff, 16'd0};
          result_q <= '0;
          if (opcode_i == nid_pkg::OP_APPEND) begin
            status_q <= (count_q < CW'(MAX_POINTS)) ? nid_pkg::ST_OK : nid_pkg::ST_FULL;
          end else if (count_q < CW'(2)) begin
            status_q <= nid_pkg::ST_FEW;
          end else begin
            status_q <= nid_pkg::ST_ZERO;
          end
        end
      end
      S_PDIV: begin
        if (div_res.done) p_q <= div_res.value;
      end
      S_COPY: begin
        if (c_q != '0 && (c_q - CW'(1)) == sel_idx) sum_q <= {{32{samp_rd_q[31]}}, samp_rd_q};
      end
      S_PASS: begin
        if (k_q >= CW'(1)) prev_q <= diff_rd_q;
        if (k_q >= CW'(2)) sat_q <= sat_q | pass_res[64];
        // the first entry written in a pass is the next coefficient
        if (k_q == CW'(2)) coef_q <= pass_res[63:0];
        if (k_q == count_q - j_q + CW'(1) && j_q == CW'(1)) prod_q <= p_q;
      end
      S_MUL1: begin
        if (mul_res.done) begin
          prod_q <= mul_res.value;
          sat_q  <= sat_q | mul_res.sat;
        end
      end
      S_MUL2: begin
        if (mul_res.done) begin
          term_q <= mul_res.value;
          sat_q  <= sat_q | mul_res.sat;
        end
      end
      S_TDIV: begin
        if (div_res.done) begin
          sum_q <= add_res[63:0];
          sat_q <= sat_q | add_res[64];
        end
      end
      S_DONE: begin
        if (sum_q[63:31] == {33{1'b0}} || sum_q[63:31] == {33{1'b1}}) begin
          result_q <= sum_q[31:0];
          status_q <= sat_q ? nid_pkg::ST_SAT : nid_pkg::ST_OK;
        end else begin
          result_q <= sum_q[63] ? 32'h8000_0000 : 32'h7fff_ffff;
          status_q <= nid_pkg::ST_SAT;
        end
      end
      default: ;
    endcase
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  // a result beat never overlaps a running query
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while busy");
  // the store never holds more points than it has entries
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");
  // the arithmetic units are never started together
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start_q && div_start_q))
    else $error("multiplier and divider started together");
  // a query that reaches the done state ends with a result beat and busy low
  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (done_o && !busy))
    else $error("query end without result beat");
`endif

endmodule

>>> dv/newton_difference_interpolator_tb.sv
// self-checking testbench of the newton difference interpolator
`timescale 1ns / 100ps

module newton_difference_interpolator_tb;

  localparam int unsigned NumPts   = 16;
  localparam int unsigned Watchdog = 40000;
  localparam logic [1:0]  OP_NOP   = 2'd3;  // unused opcode, ignored by the block
  localparam logic [2:0]  ADDR_DIR = 3'd0;  // direction register
  localparam logic [2:0]  ADDR_GAP = 3'd4;  // register index 1, does not exist

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] q;
  } cmd_t;

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         status;
  } answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode_i = OP_NOP;
  logic signed [31:0] x_value_i = '0;
  logic signed [31:0] y_value_i = '0;
  logic signed [31:0] query_point_i = '0;
  logic               done_o;
  logic signed [31:0] result_value_o;
  logic [2:0]         status_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  newton_difference_interpolator #(.MAX_POINTS(NumPts)) i_dut (.*);

  always #1 clk_i = ~clk_i;

  // pending command beats and the answers they are expected to produce
  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  int      errors = 0;
  int      stalls = 0;
  int      pushed = 0;
  bit      took   = 1'b0;
  bit      calm   = 1'b0;  // no idling in the closing part
  int      gap    = 0;

  // mirror of the block state
  logic signed [31:0] ord_mem[NumPts];
  logic signed [31:0] x_first, x_second, x_last;
  int                 npts;
  bit                 backward;

  // exact (a*b) >>> 16, saturated to 64 bits
  function automatic longint mul_q16(input longint a, input longint b, inout bit sat);
    logic signed [127:0] wa, wb, pr;
    wa = a;
    wb = b;
    pr = (wa * wb) >>> 16;
    if (pr[127:63] != {65{1'b0}} && pr[127:63] != {65{1'b1}}) begin
      sat = 1'b1;
      return pr[127] ? longint'(nid_pkg::SatMin) : longint'(nid_pkg::SatMax);
    end
    return pr[63:0];
  endfunction

  function automatic longint add_sat(input longint a, input longint b, inout bit sat);
    logic signed [64:0] r;
    r = {a[63], a} + {b[63], b};
    if (r[64] != r[63]) begin
      sat = 1'b1;
      return r[64] ? longint'(nid_pkg::SatMin) : longint'(nid_pkg::SatMax);
    end
    return r[63:0];
  endfunction

  function automatic longint sub_sat(input longint a, input longint b, inout bit sat);
    logic signed [64:0] r;
    r = {a[63], a} - {b[63], b};
    if (r[64] != r[63]) begin
      sat = 1'b1;
      return r[64] ? longint'(nid_pkg::SatMin) : longint'(nid_pkg::SatMax);
    end
    return r[63:0];
  endfunction

  // newton forward or backward sum over the stored ordinates
  function automatic longint newton_sum(input longint xq, inout bit sat);
    longint diff[NumPts];
    longint coef[NumPts];
    longint h, xref, p, sum, term, f, fact;
    int     n;
    n    = npts;
    h    = longint'(x_second) - longint'(x_first);
    xref = backward ? longint'(x_last) : longint'(x_first);
    p    = ((xq - xref) * 65536) / h;
    sum  = backward ? longint'(ord_mem[n-1]) : longint'(ord_mem[0]);
    fact = 1;
    for (int i = 0; i < n; i++) diff[i] = ord_mem[i];
    coef[0] = 0;
    for (int j = 1; j < n; j++) begin
      if (!backward) begin
        for (int i = 0; i + j < n; i++) diff[i] = sub_sat(diff[i+1], diff[i], sat);
        coef[j] = diff[0];
      end else begin
        for (int i = n - 1; i >= j; i--) diff[i] = sub_sat(diff[i], diff[i-1], sat);
        coef[j] = diff[n-1];
      end
    end
    for (int i = 1; i < n; i++) begin
      term = p;
      for (int j = 1; j < i; j++) begin
        f    = backward ? p + longint'(j) * 65536 : p - longint'(j) * 65536;
        term = mul_q16(term, f, sat);
      end
      term = mul_q16(term, coef[i], sat);
      fact = fact * i;
      term = term / fact;
      sum  = add_sat(sum, term, sat);
    end
    return sum;
  endfunction

  // update the mirror for one accepted beat and queue its answer, if any
  function automatic void predict_beat(input cmd_t c);
    answer_t a;
    longint  r;
    bit      sat;
    sat = 1'b0;
    case (c.op)
      nid_pkg::OP_APPEND: begin
        a.value = '0;
        if (npts >= NumPts) begin
          a.status = nid_pkg::ST_FULL;
        end else begin
          if (npts == 0) x_first = c.x;
          if (npts == 1) x_second = c.x;
          x_last        = c.x;
          ord_mem[npts] = c.y;
          npts++;
          a.status = nid_pkg::ST_OK;
        end
        answer_q.push_back(a);
      end
      nid_pkg::OP_QUERY: begin
        if (npts < 2) begin
          a.value  = '0;
          a.status = nid_pkg::ST_FEW;
        end else if (x_second == x_first) begin
          a.value  = '0;
          a.status = nid_pkg::ST_ZERO;
        end else begin
          r = newton_sum(longint'(c.q), sat);
          if (r > longint'(32'sh7fff_ffff)) begin
            r   = 32'sh7fff_ffff;
            sat = 1'b1;
          end
          if (r < -longint'(32'sh7fff_ffff) - 1) begin
            r   = -longint'(32'sh7fff_ffff) - 1;
            sat = 1'b1;
          end
          a.value  = r[31:0];
          a.status = sat ? nid_pkg::ST_SAT : nid_pkg::ST_OK;
        end
        answer_q.push_back(a);
      end
      nid_pkg::OP_CLEAR: npts = 0;
      default: ;
    endcase
  endfunction

  // sampling side: accepted command beats, result beats, watchdog
  always @(posedge clk_i) begin
    answer_t a;
    cmd_t    c;
    took = start && !busy && rst_ni;
    if (took) begin
      c.op = opcode_i;
      c.x  = x_value_i;
      c.y  = y_value_i;
      c.q  = query_point_i;
      predict_beat(c);
    end
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result beat value %h status %0d",
                 $time, result_value_o, status_o);
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (result_value_o !== a.value) begin
          $display("%0t: result_value expected %h actual %h", $time, a.value, result_value_o);
          errors++;
        end
        if (status_o !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, status_o);
          errors++;
        end
      end
    end
    stalls = (took || done_o) ? 0 : stalls + 1;
    if (stalls >= Watchdog) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // driving side: one beat at a time from the pending queue, with idle bursts
  always @(negedge clk_i) begin
    cmd_t c;
    if (rst_ni && (!start || took)) begin
      if (gap > 0) begin
        start <= 1'b0;
        gap   <= gap - 1;
      end else if (cmd_q.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        gap   <= $urandom_range(0, 15);
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        start         <= 1'b1;
        opcode_i      <= c.op;
        x_value_i     <= c.x;
        y_value_i     <= c.y;
        query_point_i <= c.q;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] q);
    cmd_t c;
    c.op = op;
    c.x  = x;
    c.y  = y;
    c.q  = q;
    cmd_q.push_back(c);
    if (op != OP_NOP) pushed++;
  endtask

  // all beats out and all answers back, then let beats without an answer settle
  task automatic drain();
    wait (cmd_q.size() == 0 && !start && answer_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_DIR) backward = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // clear, load a set equally spaced unless wild (then random), then query around it
  task automatic load_and_query();
    int                 n, k;
    logic signed [31:0] x0, h, yv, q;
    bit                 wild;
    wild = ($urandom_range(0, 9) == 0);
    push_cmd(nid_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(0, 1);
      1:       n = $urandom_range(9, 18);
      default: n = $urandom_range(2, 6);
    endcase
    x0 = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    h  = ($urandom_range(0, 19) == 0) ? 0 : $signed($urandom_range(1 << 12, 4 << 16));
    if ($urandom_range(0, 1)) h = -h;
    for (int i = 0; i < n; i++) begin
      yv = wild ? $urandom : $signed($urandom_range(0, 100 << 16)) - (50 << 16);
      push_cmd(nid_pkg::OP_APPEND, wild ? $urandom : x0 + i * h, yv, $urandom);
    end
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) begin
      q = wild ? $urandom : x0 + $signed($urandom_range(0, 2 << 16)) * (h >>> 16)
                            + $signed($urandom_range(0, 8 << 16)) - (2 << 16);
      push_cmd(nid_pkg::OP_QUERY, $urandom, $urandom, q);
    end
    if ($urandom_range(0, 7) == 0) push_cmd(OP_NOP, $urandom, $urandom, $urandom);
  endtask

  initial begin
    for (int i = 0; i < NumPts; i++) ord_mem[i] = '0;
    x_first  = '0;
    x_second = '0;
    x_last   = '0;
    npts     = 0;
    backward = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: too few points, zero spacing, extremes, unused opcode, full store
    push_cmd(nid_pkg::OP_QUERY, '0, '0, '0);
    push_cmd(nid_pkg::OP_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, '0);
    push_cmd(nid_pkg::OP_QUERY, '0, '0, 32'sh7fff_ffff);
    push_cmd(nid_pkg::OP_APPEND, 32'sh8000_0000, 32'sh8000_0000, '0);
    push_cmd(nid_pkg::OP_QUERY, '0, '0, 32'sh8000_0000);
    push_cmd(OP_NOP, '1, '1, '1);
    push_cmd(nid_pkg::OP_CLEAR, '0, '0, '0);
    push_cmd(nid_pkg::OP_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, '0);
    push_cmd(nid_pkg::OP_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, '0);
    push_cmd(nid_pkg::OP_APPEND, 32'sh7fff_ffff, 32'sh7fff_ffff, '0);
    push_cmd(nid_pkg::OP_QUERY, '1, '1, 32'sh7fff_ffff);
    push_cmd(nid_pkg::OP_QUERY, '0, '0, 32'sh8000_0000);
    push_cmd(nid_pkg::OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < 17; i++) push_cmd(nid_pkg::OP_APPEND, i << 16, (i * i) << 14, '0);
    push_cmd(nid_pkg::OP_QUERY, '0, '0, 32'sh0002_8000);
    drain();

    // random phases, each under its own direction setting
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(ADDR_DIR, (ph == 5) ? 32'hffff_ffff : {$urandom} | (ph & 1));
      if (ph == 2) reg_write(ADDR_GAP, 32'h0000_0000);
      if (ph == 3) reg_write(ADDR_DIR, 32'h0000_0000);
      if (ph == 5) calm = 1'b1;
      while (pushed < 60 + (ph + 1) * 100) begin
        load_and_query();
        if ($urandom_range(0, 15) == 0) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
